// ===== rtl/core/tfst_pkg.sv =====
// Shared types, constants and helpers for the touch frame slot tracker.
// No dependencies; the slot scanner and the top level refer to this package.
`default_nettype none

package tfst_pkg;

   localparam int MAX_FINGERS  = 5;
   localparam int MASK_W       = 5;
   localparam int STORE_DEPTH  = 28;
   localparam int ADDR_W       = $clog2(STORE_DEPTH);
   localparam int RECORD_BYTES = 5;
   localparam int FIRST_RECORD = 2;
   localparam int SLOT_W       = 3;

   localparam logic [ADDR_W-1:0] IDLE_INDEX = '1;
   localparam logic [MASK_W-1:0] SLOT_MASK  = MASK_W'((1 << MAX_FINGERS) - 1);

   localparam logic [7:0] STATUS_TAG_MASK = 8'hC0;
   localparam logic [7:0] STATUS_TAG      = 8'h80;
   localparam logic [3:0] RELOAD_KEY      = 4'hF;

   localparam logic [2:0] EV_CONTACT   = 3'd0;
   localparam logic [2:0] EV_RELEASE   = 3'd1;
   localparam logic [2:0] EV_NOT_READY = 3'd2;
   localparam logic [2:0] EV_RELOAD    = 3'd3;
   localparam logic [2:0] EV_CHECKSUM  = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [2:0]  slot;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [7:0]  touch_width;
      logic        last_of_frame;
   } rsp_type;

   // Start command from the byte parser to the slot scanner.
   typedef struct packed {
      logic              start;
      logic [MASK_W-1:0] cur_mask;
      logic [MASK_W-1:0] active_mask;
   } scan_cmd_type;

   // One result offered by the slot scanner.
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } scan_push_type;

   // Byte index one past the last point byte, for a given status byte.
   function automatic logic [ADDR_W-1:0] frame_end(input logic [MASK_W-1:0] bits);
      int n;
      n = 0;
      for (int i = 0; i < MASK_W; i++) begin
         n = n + int'(bits[i]);
      end
      if (n > MAX_FINGERS) begin
         n = MAX_FINGERS;
      end
      return ADDR_W'(FIRST_RECORD + RECORD_BYTES * n);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tfst_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module tfst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 28
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/tfst_scanner.sv =====
// Slot scanner: walks slots in order after a good frame, fetches point
// records from the frame RAM and offers contact/release results.
// Depends on tfst_pkg.
`default_nettype none

module tfst_scanner (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tfst_pkg::scan_cmd_type        cmd,
   input  wire logic [7:0]                    ram_rdata,
   output logic      [tfst_pkg::ADDR_W-1:0]   ram_raddr,
   output tfst_pkg::scan_push_type            push,
   input  wire logic                          push_ack,
   output logic                               busy
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_FETCH = 2'd2;
   localparam logic [1:0] S_PUSH  = 2'd3;

   logic [1:0]                    state_ff, state_in;
   logic [tfst_pkg::MASK_W-1:0]   cur_ff, cur_in;
   logic [tfst_pkg::MASK_W-1:0]   active_ff, active_in;
   logic [tfst_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic [tfst_pkg::ADDR_W-1:0]   rec_addr_ff, rec_addr_in;
   logic [2:0]                    cnt_ff, cnt_in;
   logic                          contact_ff, contact_in;
   logic [39:0]                   rec_ff, rec_in;
   logic [tfst_pkg::MASK_W-1:0]   above;
   logic                          slot_done;

   assign slot_done = (slot_ff == tfst_pkg::SLOT_W'(tfst_pkg::MAX_FINGERS));

   always_comb begin
      for (int i = 0; i < tfst_pkg::MASK_W; i++) begin
         above[i] = (tfst_pkg::SLOT_W'(i) > slot_ff);
      end
   end

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      active_in   = active_ff;
      slot_in     = slot_ff;
      rec_addr_in = rec_addr_ff;
      cnt_in      = cnt_ff;
      contact_in  = contact_ff;
      rec_in      = rec_ff;
      ram_raddr   = rec_addr_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               cur_in      = cmd.cur_mask;
               active_in   = cmd.active_mask;
               slot_in     = '0;
               rec_addr_in = tfst_pkg::ADDR_W'(tfst_pkg::FIRST_RECORD);
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            // The first record byte is read here; the rest follow in fetch.
            if (slot_done) begin
               state_in = S_IDLE;
            end else if (cur_ff[slot_ff]) begin
               contact_in = 1'b1;
               cnt_in     = 3'd1;
               state_in   = S_FETCH;
            end else if (active_ff[slot_ff]) begin
               contact_in = 1'b0;
               state_in   = S_PUSH;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         S_FETCH: begin
            ram_raddr = rec_addr_ff + tfst_pkg::ADDR_W'(cnt_ff);
            rec_in    = {rec_ff[31:0], ram_rdata};
            if (cnt_ff == 3'(tfst_pkg::RECORD_BYTES)) begin
               state_in = S_PUSH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_PUSH: begin
            if (push_ack) begin
               slot_in  = slot_ff + 1'b1;
               state_in = S_SCAN;
               if (contact_ff) begin
                  rec_addr_in = rec_addr_ff + tfst_pkg::ADDR_W'(tfst_pkg::RECORD_BYTES);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      push.valid              = (state_ff == S_PUSH);
      push.data.slot          = slot_ff;
      push.data.last_of_frame = ((active_ff & above) == '0);
      if (contact_ff) begin
         push.data.event_kind  = tfst_pkg::EV_CONTACT;
         push.data.pos_y       = rec_ff[39:24];
         push.data.pos_x       = rec_ff[23:8];
         push.data.touch_width = rec_ff[7:0];
      end else begin
         push.data.event_kind  = tfst_pkg::EV_RELEASE;
         push.data.pos_y       = '0;
         push.data.pos_x       = '0;
         push.data.touch_width = '0;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cur_ff      <= cur_in;
      active_ff   <= active_in;
      slot_ff     <= slot_in;
      rec_addr_ff <= rec_addr_in;
      cnt_ff      <= cnt_in;
      contact_ff  <= contact_in;
      rec_ff      <= rec_in;
   end

   // A record is fetched only for a slot that is touched in this frame.
   a_fetch_touched: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH) |-> cur_ff[slot_ff])
      else $error("record fetch for an untouched slot");

   // Every fetched record lies inside the frame store.
   a_fetch_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH) |->
         (rec_addr_ff <= tfst_pkg::ADDR_W'(tfst_pkg::STORE_DEPTH - tfst_pkg::RECORD_BYTES)))
      else $error("record address out of range");

   // The slot pointer never runs past the closing position of a scan.
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> (slot_ff <= tfst_pkg::SLOT_W'(tfst_pkg::MAX_FINGERS)))
      else $error("slot pointer out of range");

endmodule

`default_nettype wire

// ===== rtl/core/touch_frame_slot_tracker.sv =====
// Touch frame slot tracker, top level: byte parser, frame RAM, slot scanner
// and result register. Depends on tfst_pkg, tfst_ram and tfst_scanner.
//
// Usage: feed one frame byte per req word (status, key, five-byte point
// records, checksum), with frame_start set on the status byte. Words are
// taken while req_ready is high. Not ready, reload request and checksum
// error give one rsp word on the cycle after the offending byte. A good
// checksum starts a slot scan: the scanner visits slots 0..4 in order,
// passes over idle slots, and for a contact visits the slot, makes five
// single-byte reads from the frame RAM, which has one read port, and
// pushes; a release is visited and pushed, and a closing step ends the
// scan. req_ready stays low for the whole scan.
// The last rsp word of a frame has last_of_frame set.
// Reset clears the byte index, checksum, previous touch mask and result
// valid flag; the frame RAM is not cleared, since only bytes of the current
// frame are ever read. When rsp_ready is low and a word is held, the result
// register keeps it, the scanner waits in its push step and req_ready drops.
`default_nettype none

module touch_frame_slot_tracker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire tfst_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output tfst_pkg::rsp_type      rsp_data
);

   // Parser state
   logic [tfst_pkg::ADDR_W-1:0] byte_index_ff, byte_index_in;
   logic [7:0]                  sum_ff, sum_in;
   logic [tfst_pkg::MASK_W-1:0] prev_mask_ff, prev_mask_in;
   logic [tfst_pkg::MASK_W-1:0] status_ff, status_in;
   logic [tfst_pkg::ADDR_W-1:0] end_ff, end_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   tfst_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                        accept;
   logic [tfst_pkg::ADDR_W-1:0] idx_eff;
   logic [7:0]                  sum_eff;
   logic [tfst_pkg::MASK_W-1:0] cur_mask;
   logic                        out_free;
   logic                        err_valid;
   logic [2:0]                  err_kind;

   logic                        wr_en;
   logic [tfst_pkg::ADDR_W-1:0] ram_raddr;
   logic [7:0]                  ram_rdata;

   tfst_pkg::scan_cmd_type  scan_cmd;
   tfst_pkg::scan_push_type scan_push;
   logic                    scan_busy;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !scan_busy && out_free;
   assign accept    = req_valid && req_ready;

   // A frame start restarts counting at the status byte.
   assign idx_eff  = req_data.frame_start ? '0 : byte_index_ff;
   assign sum_eff  = req_data.frame_start ? '0 : sum_ff;
   assign cur_mask = status_ff & tfst_pkg::SLOT_MASK;
   assign wr_en    = accept && (idx_eff < tfst_pkg::ADDR_W'(tfst_pkg::STORE_DEPTH));

   always_comb begin
      byte_index_in = byte_index_ff;
      sum_in        = sum_ff;
      prev_mask_in  = prev_mask_ff;
      status_in     = status_ff;
      end_in        = end_ff;
      err_valid     = 1'b0;
      err_kind      = tfst_pkg::EV_NOT_READY;
      scan_cmd      = '0;
      if (accept) begin
         byte_index_in = idx_eff;
         sum_in        = sum_eff;
         if (wr_en) begin
            if (idx_eff == '0) begin
               sum_in = '0;
               if ((req_data.data_byte & tfst_pkg::STATUS_TAG_MASK) != tfst_pkg::STATUS_TAG) begin
                  byte_index_in = tfst_pkg::IDLE_INDEX;
                  err_valid     = 1'b1;
                  err_kind      = tfst_pkg::EV_NOT_READY;
               end else begin
                  status_in     = req_data.data_byte[tfst_pkg::MASK_W-1:0];
                  end_in        = tfst_pkg::frame_end(req_data.data_byte[tfst_pkg::MASK_W-1:0]);
                  byte_index_in = tfst_pkg::ADDR_W'(1);
               end
            end else if (idx_eff == tfst_pkg::ADDR_W'(1)) begin
               if (req_data.data_byte[3:0] == tfst_pkg::RELOAD_KEY) begin
                  byte_index_in = tfst_pkg::IDLE_INDEX;
                  err_valid     = 1'b1;
                  err_kind      = tfst_pkg::EV_RELOAD;
               end else begin
                  byte_index_in = tfst_pkg::ADDR_W'(2);
               end
            end else if (idx_eff < end_ff) begin
               // Point byte: accumulate and advance.
               sum_in        = sum_eff + req_data.data_byte;
               byte_index_in = idx_eff + 1'b1;
            end else begin
               // Checksum byte: drop to idle either way.
               byte_index_in = tfst_pkg::IDLE_INDEX;
               if (sum_eff != req_data.data_byte) begin
                  err_valid = 1'b1;
                  err_kind  = tfst_pkg::EV_CHECKSUM;
               end else begin
                  scan_cmd.start       = 1'b1;
                  scan_cmd.cur_mask    = cur_mask;
                  scan_cmd.active_mask = cur_mask | prev_mask_ff;
                  prev_mask_in         = cur_mask;
               end
            end
         end
      end
   end

   // Result register: load a scanner word or a frame error word.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (scan_push.valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = scan_push.data;
      end else if (err_valid) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in               = '0;
         rsp_data_in.event_kind    = err_kind;
         rsp_data_in.last_of_frame = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         sum_ff        <= '0;
         prev_mask_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         byte_index_ff <= byte_index_in;
         sum_ff        <= sum_in;
         prev_mask_ff  <= prev_mask_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      status_ff   <= status_in;
      end_ff      <= end_in;
      rsp_data_ff <= rsp_data_in;
   end

   tfst_ram #(
      .WIDTH(8),
      .DEPTH(tfst_pkg::STORE_DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_eff),
      .wr_data (req_data.data_byte),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   tfst_scanner u_scanner (
      .clock     (clock),
      .reset     (reset),
      .cmd       (scan_cmd),
      .ram_rdata (ram_rdata),
      .ram_raddr (ram_raddr),
      .push      (scan_push),
      .push_ack  (out_free),
      .busy      (scan_busy)
   );

   // No byte is taken while the scanner owns the result register.
   a_no_req_in_scan: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && scan_busy))
      else $error("byte accepted during slot scan");

   // Frame-level events always close the frame.
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.event_kind != tfst_pkg::EV_CONTACT &&
       rsp_data_ff.event_kind != tfst_pkg::EV_RELEASE) |-> rsp_data_ff.last_of_frame)
      else $error("frame event without last_of_frame");

   // The byte index is either inside the store or idle.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (byte_index_ff < tfst_pkg::ADDR_W'(tfst_pkg::STORE_DEPTH)) ||
      (byte_index_ff == tfst_pkg::IDLE_INDEX))
      else $error("byte index out of range");

endmodule

`default_nettype wire
